// File: rtl/core/e2q_pkg.sv
package e2q_pkg;

   localparam int ANGLE_WIDTH   = 16;
   localparam int FRAC_BITS     = 14;
   localparam int CORDIC_STAGES = 16;

   localparam int FIELD_W     = 16;
   localparam int DATA_W      = 32;
   localparam int ANGLE_ACC_W = DATA_W + 2;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int INNER_FRAC  = 30;
   localparam int MAX_STAGES  = 32;
   localparam int NUM_AXES    = 3;

   // cordic stages, pair products, component products, output
   localparam int PIPE_DEPTH = CORDIC_STAGES + 3;

   typedef logic signed [DATA_W-1:0]      cordic_data_type;
   typedef logic signed [ANGLE_ACC_W-1:0] angle_acc_type;
   typedef logic signed [PROD_W-1:0]      wide_prod_type;
   typedef logic signed [FIELD_W-1:0]     field_type;

   // cordic gain compensation, 0.6072529350 in q30
   localparam cordic_data_type CORDIC_X0 = cordic_data_type'(652032874);

   // atan(2^-i), 2^32 units per turn
   localparam logic [DATA_W-1:0] ATAN_STEPS [MAX_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

endpackage

// File: rtl/core/euler_to_quaternion.sv
// Converts roll, pitch and yaw binary angles (value * pi / 32768 rad) into the
// unit quaternion qz*qy*qx in signed Q1.14, rounded and saturated to +/-16384.
// Fully pipelined: one transfer per cycle in and out while rsp_ready is high. The
// pipe has one register per CORDIC micro-rotation (CORDIC_STAGES) plus a
// stage each for the pair products, the component products and the final
// round and saturate. Each stage holds its item under backpressure, so a stalled
// result never blocks the empty stages behind it from filling.
module euler_to_quaternion
   import e2q_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  field_type req_roll_angle,
   input  field_type req_pitch_angle,
   input  field_type req_yaw_angle,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output field_type rsp_quat_x,
   output field_type rsp_quat_y,
   output field_type rsp_quat_z,
   output field_type rsp_quat_w
);

   localparam int AXIS_X     = 0;
   localparam int AXIS_Y     = 1;
   localparam int AXIS_Z     = 2;
   localparam int PAIR_STAGE = CORDIC_STAGES;
   localparam int PROD_STAGE = CORDIC_STAGES + 1;
   localparam int OUT_STAGE  = CORDIC_STAGES + 2;
   localparam int FIN_SHIFT  = 2 * INNER_FRAC - FRAC_BITS;

   localparam wide_prod_type WIDE_ONE  = wide_prod_type'(1);
   localparam wide_prod_type PAIR_RND  = WIDE_ONE <<< (INNER_FRAC - 1);
   localparam wide_prod_type FIN_RND   = WIDE_ONE <<< (FIN_SHIFT - 1);
   localparam wide_prod_type FIN_LIMIT = WIDE_ONE <<< FRAC_BITS;

   function automatic cordic_data_type round_pair(input cordic_data_type a,
                                                  input cordic_data_type b);
      wide_prod_type p;
      p = wide_prod_type'(a) * wide_prod_type'(b) + PAIR_RND;
      return p[INNER_FRAC+DATA_W-1:INNER_FRAC];
   endfunction

   function automatic field_type finish(input wide_prod_type sum);
      wide_prod_type r;
      r = (sum + FIN_RND) >>> FIN_SHIFT;
      if (r > FIN_LIMIT) begin
         r = FIN_LIMIT;
      end
      if (r < -FIN_LIMIT) begin
         r = -FIN_LIMIT;
      end
      return r[FIELD_W-1:0];
   endfunction

   // stage valids and per-stage advance
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] advance;

   assign advance[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp_ready;

   for (genvar k = 0; k < PIPE_DEPTH - 1; k++) begin : g_adv
      assign advance[k] = !valid_ff[k] || advance[k+1];
   end

   assign valid_in  = {valid_ff[PIPE_DEPTH-2:0], req_valid};
   assign req_ready = advance[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // half angles, 2^33 per turn
   field_type     raw_angle [NUM_AXES];
   angle_acc_type angle_in  [NUM_AXES];

   assign raw_angle[AXIS_X] = req_roll_angle;
   assign raw_angle[AXIS_Y] = req_pitch_angle;
   assign raw_angle[AXIS_Z] = req_yaw_angle;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_angle
      logic [DATA_W-1:0] raw_wide;
      logic [DATA_W-1:0] raw_top;
      assign raw_wide    = {{(DATA_W-FIELD_W){1'b0}}, raw_angle[a]};
      assign raw_top     = raw_wide << (DATA_W - ANGLE_WIDTH);
      assign angle_in[a] = angle_acc_type'(signed'(raw_top));
   end

   // cordic rotation pipeline
   cordic_data_type cos_ff [CORDIC_STAGES][NUM_AXES];
   cordic_data_type sin_ff [CORDIC_STAGES][NUM_AXES];
   angle_acc_type   ang_ff [CORDIC_STAGES-1][NUM_AXES];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
         cordic_data_type x_src, y_src, x_in, y_in;
         angle_acc_type   z_src;
         logic            neg;

         if (i == 0) begin : g_first
            assign x_src = CORDIC_X0;
            assign y_src = '0;
            assign z_src = angle_in[a];
         end else begin : g_next
            assign x_src = cos_ff[i-1][a];
            assign y_src = sin_ff[i-1][a];
            assign z_src = ang_ff[i-1][a];
         end

         assign neg = z_src[ANGLE_ACC_W-1];

         always_comb begin
            if (neg) begin
               x_in = x_src + (y_src >>> i);
               y_in = y_src - (x_src >>> i);
            end else begin
               x_in = x_src - (y_src >>> i);
               y_in = y_src + (x_src >>> i);
            end
         end

         always_ff @(posedge clock) begin
            if (advance[i]) begin
               cos_ff[i][a] <= x_in;
               sin_ff[i][a] <= y_in;
            end
         end

         // residual angle is only carried where a later stage reads it
         if (i < CORDIC_STAGES - 1) begin : g_ang
            angle_acc_type step, z_in;

            assign step = angle_acc_type'({ATAN_STEPS[i], 1'b0});
            assign z_in = neg ? z_src + step : z_src - step;

            always_ff @(posedge clock) begin
               if (advance[i]) begin
                  ang_ff[i][a] <= z_in;
               end
            end
         end
      end
   end

   // pair products of yaw and pitch
   cordic_data_type czcy_ff, szsy_ff, czsy_ff, szcy_ff, sx_ff, cx_ff;

   always_ff @(posedge clock) begin
      if (advance[PAIR_STAGE]) begin
         czcy_ff <= round_pair(cos_ff[CORDIC_STAGES-1][AXIS_Z],
                               cos_ff[CORDIC_STAGES-1][AXIS_Y]);
         szsy_ff <= round_pair(sin_ff[CORDIC_STAGES-1][AXIS_Z],
                               sin_ff[CORDIC_STAGES-1][AXIS_Y]);
         czsy_ff <= round_pair(cos_ff[CORDIC_STAGES-1][AXIS_Z],
                               sin_ff[CORDIC_STAGES-1][AXIS_Y]);
         szcy_ff <= round_pair(sin_ff[CORDIC_STAGES-1][AXIS_Z],
                               cos_ff[CORDIC_STAGES-1][AXIS_Y]);
         sx_ff   <= sin_ff[CORDIC_STAGES-1][AXIS_X];
         cx_ff   <= cos_ff[CORDIC_STAGES-1][AXIS_X];
      end
   end

   // products with roll terms
   wide_prod_type czcy_sx_ff, szsy_cx_ff, czsy_cx_ff, szcy_sx_ff;
   wide_prod_type szcy_cx_ff, czsy_sx_ff, czcy_cx_ff, szsy_sx_ff;

   always_ff @(posedge clock) begin
      if (advance[PROD_STAGE]) begin
         czcy_sx_ff <= wide_prod_type'(czcy_ff) * wide_prod_type'(sx_ff);
         szsy_cx_ff <= wide_prod_type'(szsy_ff) * wide_prod_type'(cx_ff);
         czsy_cx_ff <= wide_prod_type'(czsy_ff) * wide_prod_type'(cx_ff);
         szcy_sx_ff <= wide_prod_type'(szcy_ff) * wide_prod_type'(sx_ff);
         szcy_cx_ff <= wide_prod_type'(szcy_ff) * wide_prod_type'(cx_ff);
         czsy_sx_ff <= wide_prod_type'(czsy_ff) * wide_prod_type'(sx_ff);
         czcy_cx_ff <= wide_prod_type'(czcy_ff) * wide_prod_type'(cx_ff);
         szsy_sx_ff <= wide_prod_type'(szsy_ff) * wide_prod_type'(sx_ff);
      end
   end

   // sum, round and saturate
   field_type quat_x_ff, quat_y_ff, quat_z_ff, quat_w_ff;

   always_ff @(posedge clock) begin
      if (advance[OUT_STAGE]) begin
         quat_x_ff <= finish(czcy_sx_ff - szsy_cx_ff);
         quat_y_ff <= finish(czsy_cx_ff + szcy_sx_ff);
         quat_z_ff <= finish(szcy_cx_ff - czsy_sx_ff);
         quat_w_ff <= finish(czcy_cx_ff + szsy_sx_ff);
      end
   end

   assign rsp_valid  = valid_ff[PIPE_DEPTH-1];
   assign rsp_quat_x = quat_x_ff;
   assign rsp_quat_y = quat_y_ff;
   assign rsp_quat_z = quat_z_ff;
   assign rsp_quat_w = quat_w_ff;

endmodule

// File: rtl/core/e2q_checker.sv
module e2q_checker
   import e2q_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input field_type rsp_quat_x,
   input field_type rsp_quat_y,
   input field_type rsp_quat_z,
   input field_type rsp_quat_w
);

   localparam int NORM_W = 2 * FIELD_W + 2;
   localparam logic signed [NORM_W-1:0] LIMIT       = NORM_W'(1) <<< FRAC_BITS;
   localparam logic signed [NORM_W-1:0] NORM_TARGET = NORM_W'(1) <<< (2 * FRAC_BITS);
   localparam logic signed [NORM_W-1:0] NORM_TOL    = NORM_W'(1) <<< 20;
   localparam logic CHECK_VALUES = (FRAC_BITS == 14) && (CORDIC_STAGES >= 16);

   logic signed [NORM_W-1:0] qx, qy, qz, qw, norm_sq;

   assign qx      = NORM_W'(rsp_quat_x);
   assign qy      = NORM_W'(rsp_quat_y);
   assign qz      = NORM_W'(rsp_quat_z);
   assign qw      = NORM_W'(rsp_quat_w);
   assign norm_sq = qx * qx + qy * qy + qz * qz + qw * qw;

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a free output stage must let a new transfer in
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled with free output stage");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_x) && $stable(rsp_quat_y)
         && $stable(rsp_quat_z) && $stable(rsp_quat_w))
      else $error("stalled result changed");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !CHECK_VALUES
         || (qx <= LIMIT && qx >= -LIMIT && qy <= LIMIT && qy >= -LIMIT
            && qz <= LIMIT && qz >= -LIMIT && qw <= LIMIT && qw >= -LIMIT))
      else $error("component out of range");

   // unit quaternion within rounding and cordic error
   a_unit_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !CHECK_VALUES
         || (norm_sq <= NORM_TARGET + NORM_TOL && norm_sq >= NORM_TARGET - NORM_TOL))
      else $error("quaternion not unit length");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);

// File: test/tb_top.sv
module tb_top;
   import e2q_pkg::*;

   typedef struct packed {
      field_type x;
      field_type y;
      field_type z;
      field_type w;
   } quat_type;

   typedef struct packed {
      field_type roll;
      field_type pitch;
      field_type yaw;
      logic      typed;
      quat_type  rough;
   } stim_row_type;

   typedef struct packed {
      quat_type model;
      logic     typed;
      quat_type rough;
   } quat_entry_type;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_type;

   localparam int RANDOM_ITEMS = 930;
   localparam int ROUGH_SLACK  = 4;
   localparam int LONG_HOLD    = 120;
   localparam int HOLD_AT [2]  = '{200, 650};
   localparam int DRAIN_CYCLES = 2 * PIPE_DEPTH + 10;

   // atan(2^-i), 2^32 units per turn
   localparam longint HALF_TURN_ATAN [MAX_STAGES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
      5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
   };

   localparam field_type SPECIAL_ANGLES [8] = '{
      -32768, -32767, -1, 0, 1, 16384, -16384, 32767
   };

   // approximate values only where the rotation is obvious
   localparam int NUM_ROWS = 20;
   localparam stim_row_type DIRECTED [NUM_ROWS] = '{
      '{0, 0, 0, 1'b1, '{0, 0, 0, 16384}},
      '{-32768, 0, 0, 1'b1, '{-16384, 0, 0, 0}},
      '{0, -32768, 0, 1'b1, '{0, -16384, 0, 0}},
      '{0, 0, -32768, 1'b1, '{0, 0, -16384, 0}},
      '{16384, 0, 0, 1'b1, '{11585, 0, 0, 11585}},
      '{0, 16384, 0, 1'b1, '{0, 11585, 0, 11585}},
      '{0, 0, 16384, 1'b1, '{0, 0, 11585, 11585}},
      '{32767, 0, 0, 1'b1, '{16384, 0, 0, 0}},
      '{-32768, -32768, -32768, 1'b1, '{0, 0, 0, -16384}},
      '{32767, 32767, 32767, 1'b1, '{0, 0, 0, 16384}},
      '{-1, -1, -1, 1'b0, '{0, 0, 0, 0}},
      '{1, 1, 1, 1'b0, '{0, 0, 0, 0}},
      '{-32767, 32767, -32767, 1'b0, '{0, 0, 0, 0}},
      '{32767, -32768, 0, 1'b0, '{0, 0, 0, 0}},
      '{-16384, 8192, -8192, 1'b0, '{0, 0, 0, 0}},
      '{21845, -21846, 10923, 1'b0, '{0, 0, 0, 0}},
      '{-21846, 21845, -10923, 1'b0, '{0, 0, 0, 0}},
      '{4096, -4096, 30000, 1'b0, '{0, 0, 0, 0}},
      '{1, -32768, 32767, 1'b0, '{0, 0, 0, 0}},
      '{12345, -23456, 31000, 1'b0, '{0, 0, 0, 0}}
   };

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   field_type req_roll_angle = '0;
   field_type req_pitch_angle = '0;
   field_type req_yaw_angle = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   field_type rsp_quat_x;
   field_type rsp_quat_y;
   field_type rsp_quat_z;
   field_type rsp_quat_w;

   logic     row_typed = 1'b0;
   quat_type row_rough = '0;

   quat_entry_type pending_quats [$];
   quat_entry_type arrived_entry;
   quat_entry_type accepted_entry;
   int accepted_reqs = 0;
   int checked_quats = 0;
   int mismatch_count = 0;
   int stall_run = 0;
   int longest_stall = 0;
   int holds_done = 0;

   euler_to_quaternion dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_roll_angle  (req_roll_angle),
      .req_pitch_angle (req_pitch_angle),
      .req_yaw_angle   (req_yaw_angle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_quat_x      (rsp_quat_x),
      .rsp_quat_y      (rsp_quat_y),
      .rsp_quat_z      (rsp_quat_z),
      .rsp_quat_w      (rsp_quat_w)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void half_sincos(input field_type ang, output longint sin_q,
                                       output longint cos_q);
      longint xr;
      longint yr;
      longint zr;
      longint dx;
      longint dy;
      zr = longint'(ang) * (longint'(1) << (32 - ANGLE_WIDTH));
      xr = 652032874;
      yr = 0;
      for (int i = 0; i < CORDIC_STAGES && i < MAX_STAGES; i++) begin
         dx = yr >>> i;
         dy = xr >>> i;
         if (zr >= 0) begin
            xr = xr - dx;
            yr = yr + dy;
            zr = zr - 2 * HALF_TURN_ATAN[i];
         end else begin
            xr = xr + dx;
            yr = yr - dy;
            zr = zr + 2 * HALF_TURN_ATAN[i];
         end
      end
      sin_q = yr;
      cos_q = xr;
   endfunction

   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic field_type round_sat(input longint sum);
      longint r;
      longint lim;
      lim = longint'(1) << FRAC_BITS;
      r = (sum + (longint'(1) << (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return field_type'(r);
   endfunction

   function automatic quat_type euler_to_quat(input field_type roll, input field_type pitch,
                                              input field_type yaw);
      longint sx, cx, sy, cy, sz, cz;
      longint czcy, szsy, czsy, szcy;
      quat_type q;
      half_sincos(roll, sx, cx);
      half_sincos(pitch, sy, cy);
      half_sincos(yaw, sz, cz);
      czcy = q30_mul(cz, cy);
      szsy = q30_mul(sz, sy);
      czsy = q30_mul(cz, sy);
      szcy = q30_mul(sz, cy);
      q.x = round_sat(czcy * sx - szsy * cx);
      q.y = round_sat(czsy * cx + szcy * sx);
      q.z = round_sat(szcy * cx - czsy * sx);
      q.w = round_sat(czcy * cx + szsy * sx);
      return q;
   endfunction

   function automatic field_type pick_angle();
      field_type a;
      case ($urandom_range(0, 9))
         5, 6: begin
            a = SPECIAL_ANGLES[$urandom_range(0, 7)];
         end
         7: begin
            a = field_type'($urandom_range(0, 127) - 64);
         end
         8: begin
            a = field_type'(($urandom_range(0, 3) << 14) + $urandom_range(0, 31) - 16);
         end
         9: begin
            a = field_type'(32'h1 << $urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1) a = ~a;
         end
         default: begin
            a = field_type'($urandom);
         end
      endcase
      return a;
   endfunction

   task automatic check_quat(input quat_type want, input int slack);
      quat_type got;
      got = '{rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w};
      if (int'(got.x) - int'(want.x) > slack || int'(want.x) - int'(got.x) > slack ||
          int'(got.y) - int'(want.y) > slack || int'(want.y) - int'(got.y) > slack ||
          int'(got.z) - int'(want.z) > slack || int'(want.z) - int'(got.z) > slack ||
          int'(got.w) - int'(want.w) > slack || int'(want.w) - int'(got.w) > slack) begin
         mismatch_count++;
         $display("%0t: quaternion mismatch (slack %0d) expected x %0d y %0d z %0d w %0d",
                  $time, slack, want.x, want.y, want.z, want.w);
         $display("%0t:                            actual x %0d y %0d z %0d w %0d",
                  $time, got.x, got.y, got.z, got.w);
      end
   endtask

   task automatic offer(input stim_row_type row);
      req_valid <= 1'b1;
      req_roll_angle <= row.roll;
      req_pitch_angle <= row.pitch;
      req_yaw_angle <= row.yaw;
      row_typed <= row.typed;
      row_rough <= row.rough;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_quats.size() != 0);
   endtask

   // input side
   always @(posedge clock) begin
      if (!reset && req_valid) begin
         if (req_ready) begin
            accepted_entry.model = euler_to_quat(req_roll_angle, req_pitch_angle,
                                                 req_yaw_angle);
            accepted_entry.typed = row_typed;
            accepted_entry.rough = row_rough;
            pending_quats.push_back(accepted_entry);
            accepted_reqs++;
            stall_run = 0;
         end else begin
            stall_run++;
            if (stall_run > longest_stall) longest_stall = stall_run;
         end
      end
   end

   // result side
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_quats.size() == 0) begin
            mismatch_count++;
            $display("%0t: quaternion transfer with nothing expected: x %0d y %0d z %0d w %0d",
                     $time, rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w);
         end else begin
            arrived_entry = pending_quats.pop_front();
            check_quat(arrived_entry.model, 0);
            if (arrived_entry.typed) check_quat(arrived_entry.rough, ROUGH_SLACK);
            checked_quats++;
         end
      end
   end

   initial begin : receiver
      rx_mode_type mode;
      int seg_left;
      int hold_left;
      int phase;
      mode = RX_ALWAYS;
      seg_left = 0;
      hold_left = 0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_done < 2 && accepted_reqs >= HOLD_AT[holds_done]) begin
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            phase++;
            case (mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 9) == 0);
               default: rsp_ready <= (phase % 3 == 0);
            endcase
         end
      end
   end

   initial begin : drive_requests
      int burst_left;
      int gap;
      stim_row_type row;
      burst_left = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < NUM_ROWS; n++) begin
         offer(DIRECTED[n]);
      end
      drain_wait();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_wait();
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 48);
         end
         burst_left--;
         row = '{pick_angle(), pick_angle(), pick_angle(), 1'b0, '0};
         offer(row);
      end
      drain_wait();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d angle triples accepted (%0d from the table), %0d quaternions checked",
               accepted_reqs, NUM_ROWS, checked_quats);
      $display("summary: %0d long result hold-offs, longest input backpressure %0d cycles",
               holds_done, longest_stall);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("timeout with %0d quaternions outstanding", pending_quats.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
